// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker module of the sample channel.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- rtl/dmc_pkg.sv -----
// Types, codes and constants of the delta-modulation sample channel.
// Depends on nothing; used by the top level and the testbench.
package dmc_pkg;

  typedef enum logic [1:0] {
    MODE_TICK    = 2'd0,
    MODE_WRITE   = 2'd1,
    MODE_DELIVER = 2'd2
  } dmc_mode_e;

  typedef enum logic [2:0] {
    REG_FLAGS   = 3'd0,
    REG_LEVEL   = 3'd1,
    REG_ADDRESS = 3'd2,
    REG_LENGTH  = 3'd3,
    REG_ENABLE  = 3'd4
  } dmc_reg_e;

  localparam logic [15:0] StartBase      = 16'hC000;
  localparam logic [15:0] WrapAddress    = 16'h8000;
  localparam logic [15:0] LastAddress    = 16'hFFFF;
  localparam logic [6:0]  LevelUpLimit   = 7'd125;
  localparam logic [6:0]  LevelStep      = 7'd2;
  localparam logic [3:0]  BitsPerByte    = 4'd8;
  localparam logic [1:0]  DelayEven      = 2'd2;
  localparam logic [1:0]  DelayOdd       = 2'd3;

  // Architectural state of the channel.
  typedef struct packed {
    logic        irq_enable;
    logic        loop_flag;
    logic [8:0]  rate_period;
    logic [8:0]  rate_timer;
    logic [6:0]  level;
    logic [15:0] start_address;
    logic [11:0] sample_bytes;
    logic [15:0] next_address;
    logic [11:0] bytes_left;
    logic [7:0]  buffer_byte;
    logic        buffer_full;
    logic [7:0]  shifter;
    logic [3:0]  bit_count;
    logic        silenced;
    logic        fetch_pending;
    logic        fetch_load_kind;
    logic        irq_raised;
    logic [1:0]  stop_delay;
    logic [1:0]  start_delay;
    logic        cycle_parity;
  } dmc_state_t;

  // Divider period per rate index, counted in MODE_TICK items.
  function automatic logic [8:0] rate_period_lookup(input logic [3:0] idx);
    logic [8:0] period;
    case (idx)
      4'd0:    period = 9'd428;
      4'd1:    period = 9'd380;
      4'd2:    period = 9'd340;
      4'd3:    period = 9'd320;
      4'd4:    period = 9'd286;
      4'd5:    period = 9'd254;
      4'd6:    period = 9'd226;
      4'd7:    period = 9'd214;
      4'd8:    period = 9'd190;
      4'd9:    period = 9'd160;
      4'd10:   period = 9'd142;
      4'd11:   period = 9'd128;
      4'd12:   period = 9'd106;
      4'd13:   period = 9'd84;
      4'd14:   period = 9'd72;
      default: period = 9'd54;
    endcase
    return period;
  endfunction

endpackage

// ----- rtl/dmc_in_if.sv -----
// Input channel of the sample channel: valid/ready plus one item.
// Depends on nothing.
interface dmc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [2:0] reg_select;
  logic [7:0] data_byte;

  modport source (output valid, mode, reg_select, data_byte, input ready);
  modport sink (input valid, mode, reg_select, data_byte, output ready);
endinterface

// ----- rtl/dmc_out_if.sv -----
// Result channel of the sample channel: valid/ready plus one result.
// Depends on nothing.
interface dmc_out_if;
  logic        valid;
  logic        ready;
  logic [6:0]  level_out;
  logic        irq_out;
  logic        fetch_request;
  logic        fetch_is_load;
  logic [15:0] fetch_address;
  logic        playing;

  modport source (output valid, level_out, irq_out, fetch_request, fetch_is_load,
                  fetch_address, playing, input ready);
  modport sink (input valid, level_out, irq_out, fetch_request, fetch_is_load,
                fetch_address, playing, output ready);
endinterface

// ----- rtl/delta_modulation_sample_channel_unit.sv -----
// Pipeline: two register stages; an accepted transaction is held in the input register and
// then passes through the state update into the result register.
// Throughput: one transaction per cycle while results are taken; when the result register
// waits, the input register holds one more transaction and then the input stalls.
// Reset: rst_ni clears all channel state and both valid flags asynchronously.
// Depends on dmc_pkg, dmc_in_if and dmc_out_if.
module delta_modulation_sample_channel_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  dmc_in_if.sink     in_i,
  dmc_out_if.source  out_o
);

  logic       in_valid_q;
  logic [1:0] mode_q;
  logic [2:0] sel_q;
  logic [7:0] data_q;

  logic       out_valid_q;
  logic       advance;

  dmc_pkg::dmc_state_t st_q, st_d;

  logic [6:0]  level_q;
  logic        irq_q;
  logic        fetch_req_q;
  logic        fetch_load_q;
  logic [15:0] fetch_addr_q;
  logic        playing_q;

  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      mode_q <= in_i.mode;
      sel_q  <= in_i.reg_select;
      data_q <= in_i.data_byte;
    end
  end

  // Next state for the registered item; all three kinds settle in one pass.
  always_comb begin
    st_d = st_q;
    if (advance) begin
      case (mode_q)
        dmc_pkg::MODE_TICK: begin
          st_d.cycle_parity = ~st_q.cycle_parity;
          if (st_d.stop_delay != 2'd0) begin
            st_d.stop_delay = st_d.stop_delay - 2'd1;
            if (st_d.stop_delay == 2'd0) begin
              st_d.bytes_left    = '0;
              st_d.fetch_pending = 1'b0;
            end
          end
          if (st_d.start_delay != 2'd0) begin
            st_d.start_delay = st_d.start_delay - 2'd1;
            if (st_d.start_delay == 2'd0 && !st_d.buffer_full &&
                st_d.bytes_left != '0) begin
              st_d.fetch_pending   = 1'b1;
              st_d.fetch_load_kind = 1'b1;
            end
          end
          if (st_q.rate_period != '0) begin
            if (st_q.rate_timer != '0) begin
              st_d.rate_timer = st_q.rate_timer - 9'd1;
            end else begin
              st_d.rate_timer = st_q.rate_period - 9'd1;
              if (!st_q.silenced) begin
                if (st_q.shifter[0]) begin
                  if (st_q.level <= dmc_pkg::LevelUpLimit) begin
                    st_d.level = st_q.level + dmc_pkg::LevelStep;
                  end
                end else if (st_q.level >= dmc_pkg::LevelStep) begin
                  st_d.level = st_q.level - dmc_pkg::LevelStep;
                end
              end
              st_d.shifter = {1'b0, st_q.shifter[7:1]};
              if (st_q.bit_count != '0) begin
                st_d.bit_count = st_q.bit_count - 4'd1;
              end
              if (st_d.bit_count == '0) begin
                st_d.bit_count = dmc_pkg::BitsPerByte;
                if (st_q.buffer_full) begin
                  st_d.silenced    = 1'b0;
                  st_d.shifter     = st_q.buffer_byte;
                  st_d.buffer_full = 1'b0;
                  // A reload is only raised when no delayed start is in flight.
                  if (st_d.start_delay == 2'd0 && st_d.bytes_left != '0) begin
                    st_d.fetch_pending   = 1'b1;
                    st_d.fetch_load_kind = 1'b0;
                  end
                end else begin
                  st_d.silenced = 1'b1;
                end
              end
            end
          end
        end
        dmc_pkg::MODE_WRITE: begin
          case (sel_q)
            dmc_pkg::REG_FLAGS: begin
              st_d.irq_enable  = data_q[7];
              st_d.loop_flag   = data_q[6];
              st_d.rate_period = dmc_pkg::rate_period_lookup(data_q[3:0]);
              if (!data_q[7]) begin
                st_d.irq_raised = 1'b0;
              end
            end
            dmc_pkg::REG_LEVEL: begin
              st_d.level = data_q[6:0];
            end
            dmc_pkg::REG_ADDRESS: begin
              st_d.start_address = dmc_pkg::StartBase + {2'b00, data_q, 6'b000000};
            end
            dmc_pkg::REG_LENGTH: begin
              st_d.sample_bytes = {data_q, 4'b0001};
            end
            dmc_pkg::REG_ENABLE: begin
              st_d.irq_raised = 1'b0;
              if (!data_q[4]) begin
                if (st_q.stop_delay == 2'd0) begin
                  st_d.stop_delay = st_q.cycle_parity ? dmc_pkg::DelayOdd
                                                      : dmc_pkg::DelayEven;
                end
              end else if (st_q.bytes_left == '0) begin
                st_d.next_address = st_q.start_address;
                st_d.bytes_left   = st_q.sample_bytes;
                st_d.start_delay  = st_q.cycle_parity ? dmc_pkg::DelayOdd
                                                      : dmc_pkg::DelayEven;
              end
            end
            default: begin
            end
          endcase
        end
        dmc_pkg::MODE_DELIVER: begin
          st_d.fetch_pending = 1'b0;
          if (st_q.bytes_left != '0) begin
            st_d.buffer_byte  = data_q;
            st_d.buffer_full  = 1'b1;
            st_d.next_address = (st_q.next_address == dmc_pkg::LastAddress)
                                ? dmc_pkg::WrapAddress : st_q.next_address + 16'd1;
            st_d.bytes_left   = st_q.bytes_left - 12'd1;
            if (st_d.bytes_left == '0) begin
              if (st_q.loop_flag) begin
                st_d.next_address = st_q.start_address;
                st_d.bytes_left   = st_q.sample_bytes;
              end else if (st_q.irq_enable) begin
                st_d.irq_raised = 1'b1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      level_q      <= st_d.level;
      irq_q        <= st_d.irq_raised;
      fetch_req_q  <= st_d.fetch_pending;
      fetch_load_q <= st_d.fetch_pending && st_d.fetch_load_kind;
      fetch_addr_q <= st_d.next_address;
      playing_q    <= st_d.bytes_left != '0;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.level_out     = level_q;
  assign out_o.irq_out       = irq_q;
  assign out_o.fetch_request = fetch_req_q;
  assign out_o.fetch_is_load = fetch_load_q;
  assign out_o.fetch_address = fetch_addr_q;
  assign out_o.playing       = playing_q;

endmodule

// ----- rtl/dmc_checker.sv -----
// Port-level checks of the sample channel, bound to its top level.
// Depends on assert_macros.svh and the top level's interface ports.
`include "assert_macros.svh"

module dmc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [6:0]  level_out_i,
  input logic        fetch_request_i,
  input logic        fetch_is_load_i,
  input logic [15:0] fetch_address_i,
  input logic        playing_i
);

  logic stalled;
  assign stalled = out_valid_i && !out_ready_i;

  `ASSERT_NEXT(a_result_held, clk_i, rst_ni, stalled, out_valid_i)
  `ASSERT_NEXT(a_payload_held, clk_i, rst_ni, stalled, $stable(level_out_i) && $stable(fetch_address_i))
  // A load kind only has meaning while a fetch is outstanding.
  `ASSERT_IMPLY(a_load_needs_request, clk_i, rst_ni, out_valid_i && fetch_is_load_i, fetch_request_i)
  // Fetches are only requested for a sample that still has bytes to play.
  `ASSERT_IMPLY(a_request_needs_bytes, clk_i, rst_ni, out_valid_i && fetch_request_i, playing_i)

endmodule

bind delta_modulation_sample_channel_unit dmc_checker u_dmc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .level_out_i     (out_o.level_out),
  .fetch_request_i (out_o.fetch_request),
  .fetch_is_load_i (out_o.fetch_is_load),
  .fetch_address_i (out_o.fetch_address),
  .playing_i       (out_o.playing)
);

// ----- verif/tb_delta_modulation_sample_channel_unit.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the delta-modulation sample channel unit: directed and random
// ticks, register writes and sample deliveries, checked against an in-bench channel model.
// Depends on dmc_pkg, dmc_in_if, dmc_out_if and delta_modulation_sample_channel_unit.
module tb_delta_modulation_sample_channel_unit;

  localparam logic [1:0] ModeUnused     = 2'd3;
  localparam logic [2:0] RegFirstUnused = 3'd5;
  localparam logic [7:0] IrqEnableBit   = 8'h80;
  localparam logic [7:0] LoopBit        = 8'h40;
  localparam logic [7:0] ChannelOnBit   = 8'h10;
  localparam int unsigned MaxPrinted    = 100;

  // Divider period per rate index; index 0 is the rightmost entry.
  localparam logic [15:0][8:0] DividerPeriods = {
    9'd54, 9'd72, 9'd84, 9'd106, 9'd128, 9'd142, 9'd160, 9'd190,
    9'd214, 9'd226, 9'd254, 9'd286, 9'd320, 9'd340, 9'd380, 9'd428
  };

  typedef struct packed {
    logic        irq_enable;
    logic        loop_flag;
    logic [8:0]  rate_period;
    logic [8:0]  rate_timer;
    logic [6:0]  level;
    logic [15:0] start_address;
    logic [11:0] sample_bytes;
    logic [15:0] next_address;
    logic [11:0] bytes_left;
    logic [7:0]  buffer_byte;
    logic        buffer_full;
    logic [7:0]  shifter;
    logic [3:0]  bit_count;
    logic        silenced;
    logic        fetch_pending;
    logic        fetch_load_kind;
    logic        irq_raised;
    logic        channel_enabled;
    logic [1:0]  stop_delay;
    logic [1:0]  start_delay;
    logic        cycle_parity;
  } chan_state_t;

  typedef struct packed {
    logic [6:0]  level;
    logic        irq;
    logic        fetch_request;
    logic        fetch_is_load;
    logic [15:0] fetch_address;
    logic        playing;
  } chan_outputs_t;

  logic clk_i;
  logic rst_ni;

  dmc_in_if  in_if ();
  dmc_out_if out_if ();

  delta_modulation_sample_channel_unit uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  chan_state_t   chan;
  chan_outputs_t pending_outputs[$];
  int unsigned   items_sent;
  int unsigned   results_checked;
  int unsigned   error_count;
  int unsigned   send_idle_pct;
  int unsigned   recv_idle_pct;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Timeout with %0d results still outstanding", pending_outputs.size());
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------- channel model

  function automatic void queue_fetch(input logic is_load);
    if (!chan.buffer_full && chan.bytes_left != 0) begin
      chan.fetch_pending   = 1'b1;
      chan.fetch_load_kind = is_load;
    end
  endfunction

  function automatic void rewind_sample();
    chan.next_address = chan.start_address;
    chan.bytes_left   = chan.sample_bytes;
  endfunction

  function automatic void advance_channel(input logic [1:0] kind, input logic [2:0] sel,
                                          input logic [7:0] data);
    chan_outputs_t want;
    case (kind)
      dmc_pkg::MODE_TICK: begin
        chan.cycle_parity = ~chan.cycle_parity;
        if (chan.stop_delay != 0) begin
          chan.stop_delay = chan.stop_delay - 2'd1;
          if (chan.stop_delay == 0) begin
            chan.bytes_left    = '0;
            chan.fetch_pending = 1'b0;
          end
        end
        if (chan.start_delay != 0) begin
          chan.start_delay = chan.start_delay - 2'd1;
          if (chan.start_delay == 0) queue_fetch(1'b1);
        end
        if (chan.rate_period != 0) begin
          if (chan.rate_timer != 0) begin
            chan.rate_timer = chan.rate_timer - 9'd1;
          end else begin
            chan.rate_timer = chan.rate_period - 9'd1;
            if (!chan.silenced) begin
              if (chan.shifter[0]) begin
                if (chan.level <= dmc_pkg::LevelUpLimit)
                  chan.level = chan.level + dmc_pkg::LevelStep;
              end else if (chan.level >= dmc_pkg::LevelStep) begin
                chan.level = chan.level - dmc_pkg::LevelStep;
              end
            end
            chan.shifter = chan.shifter >> 1;
            if (chan.bit_count != 0) chan.bit_count = chan.bit_count - 4'd1;
            if (chan.bit_count == 0) begin
              chan.bit_count = dmc_pkg::BitsPerByte;
              if (chan.buffer_full) begin
                chan.silenced    = 1'b0;
                chan.shifter     = chan.buffer_byte;
                chan.buffer_full = 1'b0;
                if (chan.start_delay == 0) queue_fetch(1'b0);
              end else begin
                chan.silenced = 1'b1;
              end
            end
          end
        end
      end
      dmc_pkg::MODE_WRITE: begin
        case (sel)
          dmc_pkg::REG_FLAGS: begin
            chan.irq_enable  = data[7];
            chan.loop_flag   = data[6];
            chan.rate_period = DividerPeriods[data[3:0]];
            if (!chan.irq_enable) chan.irq_raised = 1'b0;
          end
          dmc_pkg::REG_LEVEL:   chan.level = data[6:0];
          dmc_pkg::REG_ADDRESS: chan.start_address = dmc_pkg::StartBase +
                                                     {2'b00, data, 6'b000000};
          dmc_pkg::REG_LENGTH:  chan.sample_bytes = {data, 4'b0000} + 12'd1;
          dmc_pkg::REG_ENABLE: begin
            chan.irq_raised      = 1'b0;
            chan.channel_enabled = data[4];
            if (!data[4]) begin
              // A disable that is already counting down keeps its delay.
              if (chan.stop_delay == 0)
                chan.stop_delay = chan.cycle_parity ? dmc_pkg::DelayOdd : dmc_pkg::DelayEven;
            end else if (chan.bytes_left == 0) begin
              rewind_sample();
              chan.start_delay = chan.cycle_parity ? dmc_pkg::DelayOdd : dmc_pkg::DelayEven;
            end
          end
          default: ;
        endcase
      end
      dmc_pkg::MODE_DELIVER: begin
        chan.fetch_pending = 1'b0;
        if (chan.bytes_left != 0) begin
          chan.buffer_byte  = data;
          chan.buffer_full  = 1'b1;
          chan.next_address = (chan.next_address == dmc_pkg::LastAddress)
                              ? dmc_pkg::WrapAddress : chan.next_address + 16'd1;
          chan.bytes_left   = chan.bytes_left - 12'd1;
          if (chan.bytes_left == 0) begin
            if (chan.loop_flag) rewind_sample();
            else if (chan.irq_enable) chan.irq_raised = 1'b1;
          end
        end
      end
      default: ;
    endcase
    want.level         = chan.level;
    want.irq           = chan.irq_raised;
    want.fetch_request = chan.fetch_pending;
    want.fetch_is_load = chan.fetch_pending & chan.fetch_load_kind;
    want.fetch_address = chan.next_address;
    want.playing       = (chan.bytes_left != 0);
    pending_outputs.push_back(want);
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_item(input logic [1:0] kind, input logic [2:0] sel,
                           input logic [7:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.mode       <= kind;
    in_if.reg_select <= sel;
    in_if.data_byte  <= data;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    advance_channel(kind, sel, data);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic run_ticks(input int unsigned count);
    repeat (count) send_item(dmc_pkg::MODE_TICK, 3'($urandom), 8'($urandom));
  endtask

  function automatic logic [7:0] sample_byte();
    case ($urandom_range(3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Levels at and next to both clamp points.
  function automatic logic [7:0] extreme_level();
    case ($urandom_range(5))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd2;
      3:       return 8'd125;
      4:       return 8'd126;
      default: return 8'd127;
    endcase
  endfunction

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------- result checking

  task automatic report_mismatch(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
    error_count++;
    if (error_count <= MaxPrinted)
      $display("%0t: result %0d: %s expected %0h, got %0h", $time, results_checked, what,
               want, got);
  endtask

  always @(posedge clk_i) begin : check_results
    chan_outputs_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_outputs.size() == 0) begin
        report_mismatch("unexpected transaction, level", '0, 16'(out_if.level_out));
      end else begin
        want = pending_outputs.pop_front();
        if (out_if.level_out !== want.level)
          report_mismatch("level_out", 16'(want.level), 16'(out_if.level_out));
        if (out_if.irq_out !== want.irq)
          report_mismatch("irq_out", 16'(want.irq), 16'(out_if.irq_out));
        if (out_if.fetch_request !== want.fetch_request)
          report_mismatch("fetch_request", 16'(want.fetch_request), 16'(out_if.fetch_request));
        if (out_if.fetch_is_load !== want.fetch_is_load)
          report_mismatch("fetch_is_load", 16'(want.fetch_is_load), 16'(out_if.fetch_is_load));
        if (out_if.fetch_address !== want.fetch_address)
          report_mismatch("fetch_address", want.fetch_address, out_if.fetch_address);
        if (out_if.playing !== want.playing)
          report_mismatch("playing", 16'(want.playing), 16'(out_if.playing));
      end
      results_checked++;
    end
  end

  // ---------------------------------------------------------------- tests

  // Before any rate is chosen, ticks leave the output alone and stray items do nothing.
  task automatic test_idle_after_reset();
    run_ticks(2);
    send_item(dmc_pkg::MODE_DELIVER, dmc_pkg::REG_FLAGS, 8'hA5);
    send_item(ModeUnused, '1, 8'hFF);
    send_item(dmc_pkg::MODE_WRITE, RegFirstUnused, 8'hFF);
    send_item(dmc_pkg::MODE_WRITE, RegFirstUnused + 3'd2, 8'h00);
  endtask

  task automatic test_register_fields();
    send_item(dmc_pkg::MODE_WRITE, dmc_pkg::REG_LEVEL, 8'hFF);
    send_item(dmc_pkg::MODE_WRITE, dmc_pkg::REG_LEVEL, 8'h80);
    send_item(dmc_pkg::MODE_WRITE, dmc_pkg::REG_ADDRESS, 8'hFF);
    send_item(dmc_pkg::MODE_WRITE, dmc_pkg::REG_LENGTH, 8'hFF);
    send_item(dmc_pkg::MODE_WRITE, dmc_pkg::REG_FLAGS, IrqEnableBit | LoopBit | 8'h0F);
    send_item(dmc_pkg::MODE_WRITE, dmc_pkg::REG_FLAGS, 8'h30);
  endtask

  // Start delays on both tick parities, a stop delay, plus a second disable while one waits.
  task automatic test_enable_timing();
    send_item(dmc_pkg::MODE_WRITE, dmc_pkg::REG_ENABLE, ChannelOnBit);
    run_ticks(2);
    send_item(dmc_pkg::MODE_DELIVER, dmc_pkg::REG_LEVEL, 8'h00);
    run_ticks(1);
    send_item(dmc_pkg::MODE_WRITE, dmc_pkg::REG_ENABLE, 8'h00);
    send_item(dmc_pkg::MODE_WRITE, dmc_pkg::REG_ENABLE, ~ChannelOnBit);
    run_ticks(3);
    run_ticks(1);
    send_item(dmc_pkg::MODE_WRITE, dmc_pkg::REG_ENABLE, ChannelOnBit);
    run_ticks(3);
  endtask

  // A burst of deliveries from the top of the address space runs past FFFF and
  // finishes the sample with the interrupt enabled.
  task automatic test_address_wrap();
    send_item(dmc_pkg::MODE_WRITE, dmc_pkg::REG_ENABLE, 8'h00);
    run_ticks(3);
    send_item(dmc_pkg::MODE_WRITE, dmc_pkg::REG_FLAGS, IrqEnableBit | 8'h0F);
    send_item(dmc_pkg::MODE_WRITE, dmc_pkg::REG_ADDRESS, 8'hFF);
    send_item(dmc_pkg::MODE_WRITE, dmc_pkg::REG_LENGTH, 8'h04);
    send_item(dmc_pkg::MODE_WRITE, dmc_pkg::REG_ENABLE, ChannelOnBit);
    run_ticks(3);
    repeat (66) send_item(dmc_pkg::MODE_DELIVER, 3'($urandom), sample_byte());
    run_ticks(2);
  endtask

  // Well-formed playback sessions with random content, answered fetches and some noise.
  task automatic test_random_playback(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned roll;
    logic [3:0]  rate_index;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      rate_index = ($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(15, 13));
      send_item(dmc_pkg::MODE_WRITE, dmc_pkg::REG_FLAGS,
                {2'($urandom), 2'($urandom), rate_index});
      if ($urandom_range(1)) send_item(dmc_pkg::MODE_WRITE, dmc_pkg::REG_LEVEL, extreme_level());
      send_item(dmc_pkg::MODE_WRITE, dmc_pkg::REG_ADDRESS,
                ($urandom_range(7) == 0) ? 8'hFF : 8'($urandom));
      send_item(dmc_pkg::MODE_WRITE, dmc_pkg::REG_LENGTH,
                ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(1)));
      send_item(dmc_pkg::MODE_WRITE, dmc_pkg::REG_ENABLE, 8'($urandom) | ChannelOnBit);
      repeat ($urandom_range(400, 120)) begin
        if (items_sent >= stop_at) break;
        roll = $urandom_range(99);
        if (chan.fetch_pending && roll < 40) begin
          send_item(dmc_pkg::MODE_DELIVER, 3'($urandom), sample_byte());
        end else if (chan.rate_timer == 0 && !chan.silenced && roll < 60) begin
          // Put the level next to a clamp just before the divider expires.
          send_item(dmc_pkg::MODE_WRITE, dmc_pkg::REG_LEVEL,
                    extreme_level() | {1'($urandom_range(1)), 7'd0});
        end else if (roll < 3) begin
          send_item(2'($urandom), 3'($urandom), 8'($urandom));
        end else if (roll < 5) begin
          send_item(dmc_pkg::MODE_WRITE, dmc_pkg::REG_ENABLE, 8'($urandom));
        end else begin
          send_item(dmc_pkg::MODE_TICK, 3'($urandom), 8'($urandom));
        end
      end
    end
  endtask

  initial begin
    chan            = '0;
    items_sent      = 0;
    results_checked = 0;
    error_count     = 0;
    send_idle_pct   = 20;
    recv_idle_pct   = 68;
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.mode       = dmc_pkg::MODE_TICK;
    in_if.reg_select = dmc_pkg::REG_FLAGS;
    in_if.data_byte  = 8'h00;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_idle_after_reset();
    test_register_fields();
    test_enable_timing();
    test_address_wrap();
    test_random_playback(360);

    send_idle_pct = 68;
    recv_idle_pct = 20;
    test_random_playback(360);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_playback(360);

    in_if.valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d items (ticks, register writes, deliveries, stray items) under three",
             items_sent);
    $display("handshake pressure mixes; checked %0d results, %0d mismatches.",
             results_checked, error_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/dmc_pkg.sv
rtl/dmc_in_if.sv
rtl/dmc_out_if.sv
rtl/delta_modulation_sample_channel_unit.sv
rtl/dmc_checker.sv
verif/tb_delta_modulation_sample_channel_unit.sv
